// File: design/rmc_pkg.sv
// Shared types and codes for the ramped mute controller.
package rmc_pkg;

  localparam int TIME_BITS = 24;
  localparam int DUR_BITS  = 24;
  localparam int CFG_BITS  = 24;

  localparam logic [TIME_BITS-1:0] HOLD_RESET = TIME_BITS'(564480);

  // operation codes
  localparam logic [2:0] OP_MUTE    = 3'd0;
  localparam logic [2:0] OP_UNMUTE  = 3'd1;
  localparam logic [2:0] OP_PCM     = 3'd2;
  localparam logic [2:0] OP_SILENCE = 3'd3;
  localparam logic [2:0] OP_HALTED  = 3'd4;

  // reported state codes
  localparam logic [2:0] MS_RUNNING     = 3'd0;
  localparam logic [2:0] MS_MUTING_RAMP = 3'd1;
  localparam logic [2:0] MS_MUTING_HOLD = 3'd2;
  localparam logic [2:0] MS_MUTED       = 3'd3;
  localparam logic [2:0] MS_UNMUTING    = 3'd4;

  // ramper command codes
  localparam logic [2:0] CMD_NONE         = 3'd0;
  localparam logic [2:0] CMD_SET_MUTED    = 3'd1;
  localparam logic [2:0] CMD_SET_UNMUTED  = 3'd2;
  localparam logic [2:0] CMD_BEGIN_MUTE   = 3'd3;
  localparam logic [2:0] CMD_BEGIN_UNMUTE = 3'd4;
  localparam logic [2:0] CMD_STEP_MUTE    = 3'd5;
  localparam logic [2:0] CMD_STEP_UNMUTE  = 3'd6;

  // configuration register indexes
  localparam logic REG_RAMPER_PRESENT = 1'b0;
  localparam logic REG_MUTE_HOLD_TIME = 1'b1;

  typedef struct packed {
    logic [2:0]          operation;
    logic [DUR_BITS-1:0] duration;
    logic                ramp_complete;
  } rmc_evt_t;

  typedef struct packed {
    logic [2:0] mute_state;
    logic [2:0] ramper_command;
    logic       caller_blocks;
    logic       release_waiter;
  } rmc_res_t;

  typedef struct packed {
    logic                 ramper_present;
    logic [TIME_BITS-1:0] mute_hold_time;
  } rmc_cfg_t;

endpackage

// File: design/rmc_fsm.sv
// Mute sequencer state, per-event update and result register.
module rmc_fsm (
  input  logic              clk,
  input  logic              rst,
  input  rmc_pkg::rmc_cfg_t cfg,
  input  logic              accept,
  input  rmc_pkg::rmc_evt_t evt,
  input  logic              res_stall,
  output logic              res_valid,
  output rmc_pkg::rmc_res_t res
);
  import rmc_pkg::*;

  typedef enum logic [2:0] {
    RUNNING     = 3'd0,
    MUTING_RAMP = 3'd1,
    MUTING_HOLD = 3'd2,
    MUTED       = 3'd3,
    UNMUTING    = 3'd4
  } mode_t;

  mode_t                mode, mode_next;
  logic                 halted, halted_next;
  logic [TIME_BITS-1:0] hold_remaining, hold_remaining_next;
  logic [TIME_BITS-1:0] dur;
  logic [2:0]           cmd;
  logic                 block, release_w, muting, halted_eff;

  assign dur        = TIME_BITS'(evt.duration);
  assign muting     = (mode == MUTING_RAMP) || (mode == MUTING_HOLD);
  assign halted_eff = (evt.operation == OP_PCM) ? 1'b0 : halted;

  always_comb begin
    mode_next           = mode;
    halted_next         = halted_eff;
    hold_remaining_next = hold_remaining;
    cmd                 = CMD_NONE;
    block               = 1'b0;
    release_w           = 1'b0;
    case (evt.operation) inside
      OP_MUTE: begin
        if (!cfg.ramper_present) begin
          release_w = muting;
          mode_next = MUTED;
        end else if (mode == RUNNING || mode == UNMUTING) begin
          if (halted) begin
            mode_next = MUTED;
            cmd       = CMD_SET_MUTED;
          end else begin
            cmd = CMD_BEGIN_MUTE;
            if (evt.ramp_complete) begin
              mode_next = MUTED;
            end else begin
              mode_next = MUTING_RAMP;
              block     = 1'b1;
            end
          end
        end
      end
      OP_UNMUTE: begin
        if (!cfg.ramper_present) begin
          release_w = muting;
          mode_next = RUNNING;
        end else if (muting || mode == MUTED) begin
          release_w = muting;
          if (halted) begin
            mode_next = RUNNING;
            cmd       = CMD_SET_UNMUTED;
          end else begin
            cmd       = CMD_BEGIN_UNMUTE;
            mode_next = evt.ramp_complete ? RUNNING : UNMUTING;
          end
        end
      end
      OP_PCM, OP_SILENCE: begin
        unique case (mode)
          MUTING_RAMP: begin
            cmd = CMD_STEP_MUTE;
            if (evt.ramp_complete) begin
              mode_next           = MUTING_HOLD;
              hold_remaining_next = cfg.mute_hold_time;
            end
          end
          UNMUTING: begin
            cmd = CMD_STEP_UNMUTE;
            if (evt.ramp_complete) mode_next = RUNNING;
          end
          MUTING_HOLD: begin
            if (hold_remaining > dur) begin
              hold_remaining_next = hold_remaining - dur;
            end else begin
              hold_remaining_next = '0;
              mode_next           = MUTED;
              release_w           = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      OP_HALTED: begin
        halted_next         = 1'b1;
        hold_remaining_next = '0;
        if (muting) begin
          mode_next = MUTED;
          cmd       = CMD_SET_MUTED;
          release_w = 1'b1;
        end else if (mode == UNMUTING) begin
          mode_next = RUNNING;
          cmd       = CMD_SET_UNMUTED;
        end
      end
      default: begin
        halted_next = halted;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= RUNNING;
      halted         <= 1'b1;
      hold_remaining <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        mode               <= mode_next;
        halted             <= halted_next;
        hold_remaining     <= hold_remaining_next;
        res_valid          <= 1'b1;
        res.mute_state     <= 3'(mode_next);
        res.ramper_command <= cmd;
        res.caller_blocks  <= block;
        res.release_waiter <= release_w;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/ramped_mute_controller_core.sv
// Top level of the ramped mute controller.
//
// Event channel (evt_valid/evt_stall/evt): one beat per mute request, unmute
// request, pcm or silence block, or pipeline-halted notice, with the ramper's
// completion answer for this event carried in the beat.
// Result channel (res_valid/res_stall/res): exactly one beat per event with
// the new state, the ramper command, and the block/release flags.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is
// ramper_present, index 1 is mute_hold_time; always ready, write while idle.
// The result register is loaded when the event beat is taken.
// Throughput: one event per cycle while the result is not stalled; the state
// update and the hold-count subtract/compare are combinational ahead of the result register.
// When the receiver stalls, the result register holds and evt_stall is
// raised only while a held result is not being taken in that cycle.
// Reset: state running, halted set, hold count zero, no ramper, hold time
// 564480, result register empty.
module ramped_mute_controller_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          evt_valid,
  output logic                          evt_stall,
  input  rmc_pkg::rmc_evt_t             evt,
  output logic                          res_valid,
  input  logic                          res_stall,
  output rmc_pkg::rmc_res_t             res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [rmc_pkg::CFG_BITS-1:0]  cfg_data
);
  import rmc_pkg::*;

  rmc_cfg_t cfg;
  logic     accept;

  assign cfg_ready = 1'b1;
  assign evt_stall = res_valid && res_stall;
  assign accept    = evt_valid && !evt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramper_present <= 1'b0;
      cfg.mute_hold_time <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RAMPER_PRESENT: cfg.ramper_present <= cfg_data[0];
        REG_MUTE_HOLD_TIME: cfg.mute_hold_time <= TIME_BITS'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  rmc_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .evt       (evt),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

// File: design/rmc_checker.sv
// Port-level checks for the ramped mute controller, bound to the top level.
module rmc_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_stall,
  input rmc_pkg::rmc_res_t res
);
  import rmc_pkg::*;

  a_block_in_ramp: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.caller_blocks |->
      res.mute_state == MS_MUTING_RAMP && res.ramper_command == CMD_BEGIN_MUTE)
    else $error("caller_blocks without entering the mute ramp");

  a_release_leaves_muting: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.release_waiter |->
      res.mute_state == MS_MUTED || res.mute_state == MS_RUNNING ||
      res.mute_state == MS_UNMUTING)
    else $error("waiter released while still muting");

  a_set_muted_state: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.ramper_command == CMD_SET_MUTED |-> res.mute_state == MS_MUTED)
    else $error("set muted reported outside the muted state");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result beat changed");

endmodule

bind ramped_mute_controller_core rmc_port_checker u_rmc_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// File: dv/rmc_checker.sv
// Checker for the ramped mute controller: predicts each result beat and compares it.
module rmc_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         evt_valid,
  input  logic                         evt_stall,
  input  rmc_pkg::rmc_evt_t            evt,
  input  logic                         res_valid,
  input  logic                         res_stall,
  input  rmc_pkg::rmc_res_t            res,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [rmc_pkg::CFG_BITS-1:0] cfg_data,
  output int                           errors,
  output int                           outstanding,
  output int                           compared
);
  import rmc_pkg::*;

  logic                 present_q;
  logic [TIME_BITS-1:0] hold_time_q;
  logic [2:0]           mode_q;
  logic                 halted_q;
  logic [TIME_BITS-1:0] hold_q;

  rmc_res_t due_q[$];

  initial begin
    errors      = 0;
    outstanding = 0;
    compared    = 0;
  end

  // Advances the mirrored sequencer by one event and returns the beat it should report.
  task automatic advance_mute_fsm(input rmc_evt_t e, output rmc_res_t r);
    logic muting;
    r      = '0;
    muting = (mode_q == MS_MUTING_RAMP) || (mode_q == MS_MUTING_HOLD);
    case (e.operation)
      OP_MUTE: begin
        if (!present_q) begin
          r.release_waiter = muting;
          mode_q = MS_MUTED;
        end else if (mode_q == MS_RUNNING || mode_q == MS_UNMUTING) begin
          if (halted_q) begin
            mode_q = MS_MUTED;
            r.ramper_command = CMD_SET_MUTED;
          end else begin
            r.ramper_command = CMD_BEGIN_MUTE;
            if (e.ramp_complete) begin
              mode_q = MS_MUTED;
            end else begin
              mode_q = MS_MUTING_RAMP;
              r.caller_blocks = 1'b1;
            end
          end
        end
      end
      OP_UNMUTE: begin
        if (!present_q) begin
          r.release_waiter = muting;
          mode_q = MS_RUNNING;
        end else if (muting || mode_q == MS_MUTED) begin
          r.release_waiter = muting;
          if (halted_q) begin
            mode_q = MS_RUNNING;
            r.ramper_command = CMD_SET_UNMUTED;
          end else begin
            r.ramper_command = CMD_BEGIN_UNMUTE;
            mode_q = e.ramp_complete ? MS_RUNNING : MS_UNMUTING;
          end
        end
      end
      OP_PCM, OP_SILENCE: begin
        if (e.operation == OP_PCM) halted_q = 1'b0;
        if (mode_q == MS_MUTING_RAMP) begin
          r.ramper_command = CMD_STEP_MUTE;
          if (e.ramp_complete) begin
            mode_q = MS_MUTING_HOLD;
            hold_q = hold_time_q;
          end
        end else if (mode_q == MS_UNMUTING) begin
          r.ramper_command = CMD_STEP_UNMUTE;
          if (e.ramp_complete) mode_q = MS_RUNNING;
        end else if (mode_q == MS_MUTING_HOLD) begin
          if (hold_q > e.duration) begin
            hold_q = hold_q - e.duration;
          end else begin
            hold_q = '0;
            mode_q = MS_MUTED;
            r.release_waiter = 1'b1;
          end
        end
      end
      OP_HALTED: begin
        halted_q = 1'b1;
        hold_q   = '0;
        if (muting) begin
          mode_q = MS_MUTED;
          r.ramper_command = CMD_SET_MUTED;
          r.release_waiter = 1'b1;
        end else if (mode_q == MS_UNMUTING) begin
          mode_q = MS_RUNNING;
          r.ramper_command = CMD_SET_UNMUTED;
        end
      end
      default: ;
    endcase
    r.mute_state = mode_q;
  endtask

  task automatic report_miss(input rmc_res_t want, input rmc_res_t got, input logic orphan);
    errors++;
    if (errors <= 10) begin
      if (orphan)
        $display("ERROR: result beat with nothing expected: state %0d cmd %0d block %0b rel %0b",
                 got.mute_state, got.ramper_command, got.caller_blocks, got.release_waiter);
      else
        $display("ERROR: beat %0d expected state %0d cmd %0d block %0b rel %0b, %s",
                 compared, want.mute_state, want.ramper_command, want.caller_blocks,
                 want.release_waiter,
                 $sformatf("got %0d %0d %0b %0b", got.mute_state, got.ramper_command,
                           got.caller_blocks, got.release_waiter));
    end
  endtask

  always @(posedge clk) begin
    rmc_res_t want;
    if (rst) begin
      present_q   = 1'b0;
      hold_time_q = HOLD_RESET;
      mode_q      = MS_RUNNING;
      halted_q    = 1'b1;
      hold_q      = '0;
      due_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RAMPER_PRESENT) present_q = cfg_data[0];
        else hold_time_q = cfg_data[TIME_BITS-1:0];
      end
      // results leave before this edge's event is queued
      if (res_valid && !res_stall) begin
        if (due_q.size() == 0) begin
          report_miss('0, res, 1'b1);
        end else begin
          want = due_q.pop_front();
          if (res.mute_state !== want.mute_state || res.ramper_command !== want.ramper_command ||
              res.caller_blocks !== want.caller_blocks ||
              res.release_waiter !== want.release_waiter)
            report_miss(want, res, 1'b0);
        end
        compared++;
      end
      if (evt_valid && !evt_stall) begin
        advance_mute_fsm(evt, want);
        due_q.push_back(want);
      end
      outstanding <= due_q.size();
    end
  end

endmodule

// File: dv/testbench.sv
// Testbench top for the ramped mute controller: stimulus, pacing and verdict.
module testbench;
  import rmc_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 260;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 evt_valid;
  logic                 evt_stall;
  rmc_evt_t             evt;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  rmc_res_t             res;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_index;
  logic [CFG_BITS-1:0]  cfg_data;

  int errors;
  int outstanding;
  int compared;

  int                   n_events;
  int                   n_settings;
  int                   n_cycles;
  int                   burst_left;
  int                   quiet_cycles;
  logic [TIME_BITS-1:0] hold_cur;

  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;
  logic [3:0] rx_tick = '0;

  ramped_mute_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rmc_checker chk (
    .clk         (clk),
    .rst         (rst),
    .evt_valid   (evt_valid),
    .evt_stall   (evt_stall),
    .evt         (evt),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding),
    .compared    (compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern, re-chosen when its random run count expires
  always @(posedge clk) begin
    rx_tick <= rx_tick + 4'd1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(40, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:  res_stall <= 1'b0;
      RX_LIGHT: res_stall <= ($urandom_range(0, 99) < 30);
      RX_HEAVY: res_stall <= ($urandom_range(0, 99) < 80);
      default:  res_stall <= (rx_tick < 4'd11);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (evt_valid && !evt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("** ramped_mute_controller_core: FAILED **");
      $finish;
    end
  end

  function automatic rmc_evt_t mk_evt(logic [2:0] op, logic [DUR_BITS-1:0] dur, logic done);
    rmc_evt_t e;
    e.operation     = op;
    e.duration      = dur;
    e.ramp_complete = done;
    return e;
  endfunction

  function automatic logic [DUR_BITS-1:0] rand_dur();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return DUR_BITS'($urandom);
      default: return DUR_BITS'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic logic [2:0] audio_op();
    return ($urandom_range(0, 1) != 0) ? OP_PCM : OP_SILENCE;
  endfunction

  function automatic rmc_evt_t rand_event();
    rmc_evt_t    e;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 14)      e.operation = OP_MUTE;
    else if (pick < 28) e.operation = OP_UNMUTE;
    else if (pick < 58) e.operation = OP_PCM;
    else if (pick < 82) e.operation = OP_SILENCE;
    else if (pick < 93) e.operation = OP_HALTED;
    else                e.operation = OP_HALTED + 3'($urandom_range(1, 3));
    e.duration      = rand_dur();
    e.ramp_complete = ($urandom_range(0, 2) == 0);
    return e;
  endfunction

  // one beat, then the sender's burst/gap pacing
  task automatic send_evt(input rmc_evt_t e);
    evt       <= e;
    evt_valid <= 1'b1;
    do @(posedge clk); while (evt_stall);
    n_events++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      evt_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 15);
    end
  endtask

  task automatic wait_drain();
    evt_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_regs(input logic present, input logic [TIME_BITS-1:0] hold);
    cfg_index <= REG_RAMPER_PRESENT;
    cfg_data  <= CFG_BITS'(present);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_MUTE_HOLD_TIME;
    cfg_data  <= CFG_BITS'(hold);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hold_cur = hold;
    n_settings++;
  endtask

  // pcm, mute with ramp steps, hold countdown, unmute with ramp steps
  task automatic run_mute_cycle();
    int unsigned span;
    int unsigned half;
    span = 32'(hold_cur);
    half = span / 2 + 1;
    send_evt(mk_evt(OP_PCM, rand_dur(), 1'($urandom_range(0, 1))));
    send_evt(mk_evt(OP_MUTE, rand_dur(), $urandom_range(0, 5) == 0));
    repeat ($urandom_range(0, 3)) send_evt(mk_evt(audio_op(), rand_dur(), 1'b0));
    send_evt(mk_evt(audio_op(), rand_dur(), 1'b1));
    repeat ($urandom_range(0, 3))
      send_evt(mk_evt(audio_op(), DUR_BITS'($urandom_range(0, half)),
                      1'($urandom_range(0, 1))));
    if ($urandom_range(0, 9) == 0) send_evt(mk_evt(OP_HALTED, rand_dur(), 1'b0));
    send_evt(mk_evt(audio_op(), DUR_BITS'($urandom_range(half, span + 1)),
                    1'($urandom_range(0, 1))));
    send_evt(mk_evt(OP_UNMUTE, rand_dur(), $urandom_range(0, 3) == 0));
    repeat ($urandom_range(0, 3)) send_evt(mk_evt(audio_op(), rand_dur(), 1'b0));
    send_evt(mk_evt(audio_op(), rand_dur(), 1'b1));
    n_cycles++;
  endtask

  initial begin
    logic                 present;
    logic [TIME_BITS-1:0] hold;
    int                   phase_end;
    rst        = 1'b1;
    evt_valid  = 1'b0;
    evt        = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_RAMPER_PRESENT;
    cfg_data   = '0;
    n_events   = 0;
    n_settings = 0;
    n_cycles   = 0;
    burst_left = 0;
    hold_cur   = HOLD_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no ramper: immediate mute/unmute, halted, unused code
    send_evt(mk_evt(OP_MUTE, '0, 1'b0));
    send_evt(mk_evt(OP_UNMUTE, '0, 1'b1));
    send_evt(mk_evt(OP_HALTED, '1, 1'b0));
    send_evt(mk_evt(3'(OP_HALTED + 3'($urandom_range(1, 3))), '1, 1'b1));
    wait_drain();
    set_regs(1'b1, TIME_BITS'(3));
    send_evt(mk_evt(OP_PCM, '0, 1'b1));
    send_evt(mk_evt(OP_MUTE, '0, 1'b0));
    send_evt(mk_evt(OP_SILENCE, DUR_BITS'(5), 1'b0));
    send_evt(mk_evt(OP_PCM, '0, 1'b1));
    send_evt(mk_evt(OP_SILENCE, DUR_BITS'(1), 1'b0));
    send_evt(mk_evt(OP_SILENCE, DUR_BITS'(2), 1'b0));   // equal to remaining hold
    send_evt(mk_evt(OP_UNMUTE, '0, 1'b0));
    send_evt(mk_evt(OP_PCM, '0, 1'b1));
    send_evt(mk_evt(OP_MUTE, '0, 1'b1));
    send_evt(mk_evt(OP_UNMUTE, '0, 1'b1));
    send_evt(mk_evt(OP_MUTE, '0, 1'b0));
    send_evt(mk_evt(OP_UNMUTE, '0, 1'b0));
    send_evt(mk_evt(OP_HALTED, '0, 1'b1));
    send_evt(mk_evt(OP_MUTE, '0, 1'b0));
    send_evt(mk_evt(OP_UNMUTE, '0, 1'b0));
    send_evt(mk_evt(OP_PCM, '1, 1'b0));
    send_evt(mk_evt(OP_MUTE, '0, 1'b0));
    send_evt(mk_evt(OP_PCM, '0, 1'b1));
    send_evt(mk_evt(OP_SILENCE, '1, 1'b0));
    send_evt(mk_evt(OP_UNMUTE, '0, 1'b0));
    send_evt(mk_evt(OP_MUTE, '0, 1'b0));
    send_evt(mk_evt(OP_HALTED, '0, 1'b0));
    send_evt(mk_evt(OP_PCM, '0, 1'b0));
    send_evt(mk_evt(OP_MUTE, '0, 1'b0));
    wait_drain();
    // ramper detached, then unmute while muted
    set_regs(1'b0, TIME_BITS'(3));
    send_evt(mk_evt(OP_UNMUTE, '0, 1'b0));

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       begin present = 1'b1; hold = '0; end
        1:       begin present = 1'b1; hold = TIME_BITS'(1); end
        2:       begin present = 1'b1; hold = TIME_BITS'($urandom_range(2, 4000)); end
        3:       begin present = 1'b0; hold = TIME_BITS'($urandom); end
        4:       begin present = 1'b1; hold = '1; end
        5:       begin present = 1'b1; hold = HOLD_RESET; end
        default: begin present = 1'b1; hold = TIME_BITS'($urandom); end
      endcase
      wait_drain();
      set_regs(present, hold);
      phase_end = n_events + PHASE_ITEMS;
      while (n_events < phase_end) begin
        if ($urandom_range(0, 99) < 60) run_mute_cycle();
        else send_evt(rand_event());
        if ($urandom_range(0, 99) == 0) wait_drain();
      end
    end

    wait_drain();
    repeat (4) @(posedge clk);
    $display("Covered %0d events (%0d full mute/unmute cycles) under %0d register settings,",
             n_events, n_cycles, n_settings);
    $display("with %0d result beats compared under random receiver stalls.", compared);
    if (errors == 0 && outstanding == 0)
      $display("** ramped_mute_controller_core: PASSED **");
    else
      $display("** ramped_mute_controller_core: FAILED **");
    $finish;
  end

endmodule

// File: ramped_mute_controller_core.f
design/rmc_pkg.sv
design/rmc_fsm.sv
design/ramped_mute_controller_core.sv
design/rmc_checker.sv
dv/rmc_checker.sv
dv/testbench.sv
